FILE: src/mhpq_pkg.sv
// Shared constants, types and codes for the min-heap priority queue.
package mhpq_pkg;

    // Heap size and derived widths.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Child indexes reach 2 * CAPACITY, so they carry one extra bit over a count.
    localparam int CHILD_W  = IDX_W + 2;
    localparam int KEY_W    = 32;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CHILD_W-1:0]      t_child;

    // Operation codes.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: src/mhpq_ram.sv
// Heap storage: one write port and two registered read ports.
module mhpq_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

FILE: src/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: sift sequencer around the heap RAM.
// Insert: the new key climbs one level per S_UP step, one RAM read and compare each, and is
//   written into its final hole; a key into an empty heap goes straight to the root.
// Extract: root and last entry are fetched for S_LOAD, then the moved key sinks one level per
//   S_DOWN step; with at most one key left, S_LOAD answers. A refused operation answers from idle.
// Busy clears with the strobe; synchronous active-low reset empties the heap; no stalls.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [KEY_W-1:0]  i_key_in,
    output logic              o_strobe,
    output logic [KEY_W-1:0]  o_key_out,
    output logic [STAT_W-1:0] o_status,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    t_cnt              r_cnt, n_cnt;
    t_idx              r_pos, n_pos;
    t_key              r_key, n_key;
    t_key              r_root, n_root;
    logic              r_strobe, n_strobe;
    t_key              r_key_out, n_key_out;
    logic [STAT_W-1:0] r_status, n_status;

    logic              ram_we;
    t_idx              ram_waddr, ram_raddr_a, ram_raddr_b;
    t_key              ram_wdata;
    logic [KEY_W-1:0]  rd_a_raw, rd_b_raw;
    t_key              rd_a, rd_b;

    t_idx              par_idx, grand_idx;
    t_child            cl, cr, cnt_ext, pick, nl;
    logic              has_r, take_r;
    t_key              cval;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .DW    (KEY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a_raw),
        .o_rdata_b (rd_b_raw)
    );

    assign rd_a = $signed(rd_a_raw);
    assign rd_b = $signed(rd_b_raw);

    // Index arithmetic for the current hole position.
    always_comb begin
        par_idx   = (r_pos - IDX_W'(1)) >> 1;
        grand_idx = (par_idx - IDX_W'(1)) >> 1;
        cl        = CHILD_W'({r_pos, 1'b1});
        cr        = cl + CHILD_W'(1);
        cnt_ext   = CHILD_W'(r_cnt);
        has_r     = cr < cnt_ext;
        take_r    = has_r && (rd_b < rd_a);
        pick      = take_r ? cr : cl;
        cval      = take_r ? rd_b : rd_a;
        nl        = CHILD_W'({pick[IDX_W-1:0], 1'b1});
    end

    // Sequencer: the moving key stays in r_key while the hole walks the heap, so each
    // level takes one RAM write and the next read. Reads always target other entries
    // than the write of the same cycle, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_key       = r_key;
        n_root      = r_root;
        n_strobe    = 1'b0;
        n_key_out   = r_key_out;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_key;
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_INSERT) begin
                        if (r_cnt == CNT_W'(CAPACITY)) begin
                            n_strobe  = 1'b1;
                            n_key_out = '0;
                            n_status  = ST_FULL;
                        end else begin
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_key  = $signed(i_key_in);
                            n_root = '0;
                            n_pos  = r_cnt[IDX_W-1:0];
                            if (r_cnt == '0) begin
                                // First key goes straight to the root.
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = $signed(i_key_in);
                                n_strobe  = 1'b1;
                                n_key_out = '0;
                                n_status  = ST_OK;
                            end else begin
                                ram_raddr_a = (r_cnt[IDX_W-1:0] - IDX_W'(1)) >> 1;
                                n_state     = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_strobe  = 1'b1;
                            n_key_out = '0;
                            n_status  = ST_EMPTY;
                        end else begin
                            // Fetch the root and the last entry together.
                            n_cnt       = r_cnt - CNT_W'(1);
                            n_pos       = '0;
                            ram_raddr_a = '0;
                            ram_raddr_b = IDX_W'(r_cnt - CNT_W'(1));
                            n_state     = S_LOAD;
                        end
                    end
                end
            end

            S_UP: begin
                // Parent entry is on read port A.
                if (r_key < rd_a) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_a;
                    n_pos     = par_idx;
                    if (par_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        ram_raddr_a = grand_idx;
                    end
                end else begin
                    ram_we    = 1'b1;
                    n_strobe  = 1'b1;
                    n_key_out = '0;
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end
            end

            S_LOAD: begin
                // Root on port A, former last entry on port B; r_cnt already decremented.
                n_root = rd_a;
                n_key  = rd_b;
                if (r_cnt == '0) begin
                    n_strobe  = 1'b1;
                    n_key_out = rd_a;
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end else if (cl >= cnt_ext) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_b;
                    n_strobe  = 1'b1;
                    n_key_out = rd_a;
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end else begin
                    ram_raddr_a = cl[IDX_W-1:0];
                    ram_raddr_b = cr[IDX_W-1:0];
                    n_state     = S_DOWN;
                end
            end

            S_DOWN: begin
                // Left child on port A, right child on port B when it exists.
                if (cval < r_key) begin
                    ram_we    = 1'b1;
                    ram_wdata = cval;
                    n_pos     = pick[IDX_W-1:0];
                    if (nl >= cnt_ext) begin
                        n_state = S_FIN;
                    end else begin
                        ram_raddr_a = nl[IDX_W-1:0];
                        ram_raddr_b = IDX_W'(nl + CHILD_W'(1));
                    end
                end else begin
                    ram_we    = 1'b1;
                    n_strobe  = 1'b1;
                    n_key_out = r_root;
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end
            end

            S_FIN: begin
                // Drop the moving key into the final hole.
                ram_we    = 1'b1;
                n_strobe  = 1'b1;
                n_key_out = r_root;
                n_status  = ST_OK;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_root    <= n_root;
        r_key_out <= n_key_out;
        r_status  <= n_status;
    end

    // Occupancy is the count folded to the field width.
    assign occ_ext     = {{OCC_W{1'b0}}, r_cnt};
    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_key_out   = r_key_out;
    assign o_status    = r_status;
    assign o_occupancy = occ_ext[OCC_W-1:0];

endmodule
